### rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/bcc_pkg.sv
package bcc_pkg;

    // Subflow table size and index width
    localparam int MAX_SUBFLOWS = 8;
    localparam int SUB_W        = 3;

    // Segment size after reset
    localparam logic [15:0] SEG_SIZE_RESET = 16'd1460;

    // Item function codes
    localparam logic [1:0] FUNC_SET     = 2'd0;
    localparam logic [1:0] FUNC_ACK     = 2'd1;
    localparam logic [1:0] FUNC_LOSS    = 2'd2;
    localparam logic [1:0] FUNC_DISABLE = 2'd3;

    // Divider iteration count width
    localparam int DIV_N_W = 7;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] nbits;
        logic [63:0]        dividend;
        logic [39:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage

### rtl/bcc_ifs.sv
// Configuration write channel
interface bcc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] segment_size;
    modport source (output valid, output segment_size, input ready);
    modport sink (input valid, input segment_size, output ready);
endinterface

// Input item channel
interface bcc_item_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 func;
    logic [bcc_pkg::SUB_W-1:0]  subflow_index;
    logic [31:0]                window_bytes_in;
    logic [23:0]                rtt_micros;
    modport source (output valid, output func, output subflow_index,
                    output window_bytes_in, output rtt_micros, input ready);
    modport sink (input valid, input func, input subflow_index,
                  input window_bytes_in, input rtt_micros, output ready);
endinterface

// Result channel
interface bcc_result_if;
    logic                       valid;
    logic                       ready;
    logic [bcc_pkg::SUB_W-1:0]  subflow_out;
    logic [31:0]                window_bytes_out;
    logic [31:0]                threshold_bytes_out;
    logic [31:0]                increase_limit_q8;
    logic [23:0]                decrease_packets;
    modport source (output valid, output subflow_out, output window_bytes_out,
                    output threshold_bytes_out, output increase_limit_q8,
                    output decrease_packets, input ready);
    modport sink (input valid, input subflow_out, input window_bytes_out,
                  input threshold_bytes_out, input increase_limit_q8,
                  input decrease_packets, output ready);
endinterface

### rtl/bcc_div.sv
// Restoring divider, one quotient bit per cycle.
// The dividend arrives left aligned; nbits steps are run.
module bcc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  bcc_pkg::div_req_t req,
    output bcc_pkg::div_rsp_t rsp
);

    logic [63:0] q_reg;
    logic [39:0] rem_reg;
    logic [39:0] div_reg;
    logic [bcc_pkg::DIV_N_W-1:0] cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [40:0] trial;
    logic [40:0] diff;
    logic        fits;

    // Trial subtract of the shifted partial remainder
    assign trial = {rem_reg, q_reg[63]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = (trial >= {1'b0, div_reg});

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= req.nbits;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == bcc_pkg::DIV_N_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= req.dividend;
            rem_reg <= '0;
            div_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[39:0] : trial[39:0];
            q_reg   <= {q_reg[62:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

### rtl/multipath_balanced_cwnd_control.sv
// Balanced multipath congestion window control over a table of subflows.
// Channels: cfg writes the segment size (always ready); item carries func,
// subflow_index, window_bytes_in and rtt_micros; result returns one item per
// input with the entry's window, ssthresh, increase limit and decrease.
// One item is processed at a time; item.ready is high only while idle.
// Set and disable go from the table read straight to the result. A loss with
// a nonzero segment size runs the divider for the window in packets and scans
// the table when the decrease test applies. An ack runs the single divider,
// one bit per cycle, once for the window in packets and once per eligible
// subflow rate; unless the current subflow has no rate, normalize shifts, the
// divider once more for the ratio and a shift-add multiply follow.
// Reset clears the subflow table (windows 0, ssthresh all ones, counters 0,
// RTT 0, all disabled) and loads a segment size of 1460.
// When the receiver stalls, the result is held on the result channel and no
// new item is accepted until it is transferred.
module multipath_balanced_cwnd_control (
    input  logic          clk,
    input  logic          rst_n,
    bcc_cfg_if.sink       cfg,
    bcc_item_if.sink      item,
    bcc_result_if.source  result
);

    localparam int NSUB = bcc_pkg::MAX_SUBFLOWS;
    localparam logic [bcc_pkg::SUB_W-1:0] LAST_SUB = bcc_pkg::SUB_W'(NSUB - 1);

    // Sequencer states
    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_RDCUR     = 5'd1;
    localparam logic [4:0] S_GOTCUR    = 5'd2;
    localparam logic [4:0] S_CQDIV     = 5'd3;
    localparam logic [4:0] S_RS_RD     = 5'd4;
    localparam logic [4:0] S_RS_CHK    = 5'd5;
    localparam logic [4:0] S_RS_DIV    = 5'd6;
    localparam logic [4:0] S_CCHK      = 5'd7;
    localparam logic [4:0] S_NORM      = 5'd8;
    localparam logic [4:0] S_SUM       = 5'd9;
    localparam logic [4:0] S_MUL_SS    = 5'd10;
    localparam logic [4:0] S_MUL_DEN   = 5'd11;
    localparam logic [4:0] S_RATIO_ST  = 5'd12;
    localparam logic [4:0] S_RATIO_DIV = 5'd13;
    localparam logic [4:0] S_LIM_MUL   = 5'd14;
    localparam logic [4:0] S_LIM_FIN   = 5'd15;
    localparam logic [4:0] S_APPLY     = 5'd16;
    localparam logic [4:0] S_LDIV      = 5'd17;
    localparam logic [4:0] S_LS_RD     = 5'd18;
    localparam logic [4:0] S_LS_M1     = 5'd19;
    localparam logic [4:0] S_LS_M2     = 5'd20;
    localparam logic [4:0] S_LS_CMP    = 5'd21;
    localparam logic [4:0] S_LDEC      = 5'd22;
    localparam logic [4:0] S_LMUL      = 5'd23;
    localparam logic [4:0] S_OUT       = 5'd24;

    logic [4:0]  state_reg;
    logic [15:0] seg_size_reg;

    // Latched item
    logic [1:0]                func_reg;
    logic [bcc_pkg::SUB_W-1:0] idx_reg;
    logic [31:0]               win_in_reg;
    logic [23:0]               rtt_in_reg;

    // Subflow table
    logic [31:0] win_tab_reg  [NSUB];
    logic [31:0] ssth_tab_reg [NSUB];
    logic [31:0] ack_tab_reg  [NSUB];
    logic [23:0] rtt_tab_reg  [NSUB];
    logic        en_tab_reg   [NSUB];

    // Registered table read port
    logic [31:0] rd_win_reg;
    logic [23:0] rd_rtt_reg;
    logic        rd_en_reg;
    logic [31:0] rd_ssth_reg;
    logic [31:0] rd_ack_reg;

    // Current entry
    logic [31:0] cur_win_reg;
    logic [23:0] cur_rtt_reg;
    logic [31:0] cur_ack_reg;

    // Ack datapath
    logic [bcc_pkg::SUB_W-1:0] scan_reg;
    logic [47:0] rate_reg [NSUB];
    logic [47:0] m_reg;
    logic [47:0] c_reg;
    logic [20:0] s_reg;
    logic [55:0] prod_reg;
    logic [55:0] p2_reg;
    logic [45:0] tenss_reg;
    logic [39:0] den_reg;
    logic [57:0] ratio_reg;
    logic [43:0] acc_reg;
    logic        sat_reg;
    logic [39:0] mulsh_reg;
    logic [5:0]  bitcnt_reg;
    logic [39:0] cwnd_reg;
    logic [39:0] fallback_reg;
    logic [39:0] limit_reg;

    // Loss datapath
    logic [31:0] pe_reg;
    logic [30:0] half_reg;
    logic        big_reg;
    logic [31:0] dec_reg;

    // Result registers
    logic [bcc_pkg::SUB_W-1:0] o_sub_reg;
    logic [31:0] o_win_reg;
    logic [31:0] o_ssth_reg;
    logic [31:0] o_lim_reg;
    logic [23:0] o_dec_reg;

    // Combinational helpers
    logic [bcc_pkg::SUB_W-1:0] rd_addr;
    logic [15:0] mss_eff;
    logic        rd_elig;
    logic [31:0] mul_a;
    logic [23:0] mul_b;
    logic [55:0] mul_p;
    logic [18:0] cm_sum;
    logic [20:0] c4m_sum;
    logic [59:0] lim_sum;
    logic [31:0] lim32;
    logic [31:0] dec_raw;
    logic [31:0] pe_m1;
    logic [32:0] wsum;
    logic [63:0] quot;
    bcc_pkg::div_req_t div_req;
    bcc_pkg::div_rsp_t div_rsp;

    bcc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign quot    = div_rsp.quotient;
    assign mss_eff = (seg_size_reg == 16'd0) ? 16'd1 : seg_size_reg;
    assign rd_elig = rd_en_reg && (rd_rtt_reg != 24'd0);
    assign cm_sum  = {1'b0, c_reg[17:0]} + {1'b0, m_reg[17:0]};
    assign c4m_sum = {1'b0, c_reg[17:0], 2'b00} + {3'b000, m_reg[17:0]};
    assign lim_sum = {15'd0, acc_reg, 1'b0} + (mulsh_reg[39] ? {2'b00, ratio_reg} : 60'd0);
    assign lim32   = sat_reg ? 32'hFFFF_FFFF : acc_reg[43:12];
    assign dec_raw = big_reg ? ({1'b0, half_reg} + {2'b00, half_reg[30:1]})
                             : {1'b0, half_reg};
    assign pe_m1   = pe_reg - 32'd1;
    assign wsum    = {1'b0, cur_win_reg} + {17'd0, seg_size_reg};
    assign mul_p   = 56'(mul_a) * 56'(mul_b);

    // Table read address: scan index while walking the table
    always_comb
    begin
        if (state_reg inside {S_RS_RD, S_RS_CHK, S_RS_DIV, S_LS_RD, S_LS_M1,
                              S_LS_M2, S_LS_CMP})
            rd_addr = scan_reg;
        else
            rd_addr = idx_reg;
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL_SS:
            begin
                mul_a = {11'd0, s_reg};
                mul_b = {3'd0, s_reg};
            end
            S_MUL_DEN:
            begin
                mul_a = {13'd0, cm_sum};
                mul_b = {3'd0, c4m_sum};
            end
            S_LS_M1:
            begin
                mul_a = rd_win_reg;
                mul_b = cur_rtt_reg;
            end
            S_LS_M2:
            begin
                mul_a = cur_win_reg;
                mul_b = rd_rtt_reg;
            end
            S_LMUL:
            begin
                mul_a = pe_reg - dec_reg;
                mul_b = {8'd0, seg_size_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider launch
    always_comb
    begin
        div_req = '0;
        case (state_reg)
            S_GOTCUR:
            begin
                if (func_reg == bcc_pkg::FUNC_ACK)
                begin
                    div_req.start    = 1'b1;
                    div_req.nbits    = 7'd40;
                    div_req.dividend = {rd_win_reg, 32'd0};
                    div_req.divisor  = {24'd0, mss_eff};
                end
                else if (func_reg == bcc_pkg::FUNC_LOSS && seg_size_reg != 16'd0)
                begin
                    div_req.start    = 1'b1;
                    div_req.nbits    = 7'd32;
                    div_req.dividend = {rd_win_reg, 32'd0};
                    div_req.divisor  = {24'd0, seg_size_reg};
                end
            end
            S_RS_CHK:
            begin
                if (rd_elig)
                begin
                    div_req.start    = 1'b1;
                    div_req.nbits    = 7'd48;
                    div_req.dividend = {rd_win_reg, 32'd0};
                    div_req.divisor  = {16'd0, rd_rtt_reg};
                end
            end
            S_RATIO_ST:
            begin
                div_req.start    = 1'b1;
                div_req.nbits    = 7'd58;
                div_req.dividend = {tenss_reg, 18'd0};
                div_req.divisor  = den_reg;
            end
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    // Sequencer, table and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            seg_size_reg <= bcc_pkg::SEG_SIZE_RESET;
            for (int i = 0; i < NSUB; i++)
            begin
                win_tab_reg[i]  <= '0;
                ssth_tab_reg[i] <= '1;
                ack_tab_reg[i]  <= '0;
                rtt_tab_reg[i]  <= '0;
                en_tab_reg[i]   <= 1'b0;
                rate_reg[i]     <= '0;
            end
            func_reg     <= '0;
            idx_reg      <= '0;
            win_in_reg   <= '0;
            rtt_in_reg   <= '0;
            rd_win_reg   <= '0;
            rd_rtt_reg   <= '0;
            rd_en_reg    <= 1'b0;
            rd_ssth_reg  <= '0;
            rd_ack_reg   <= '0;
            cur_win_reg  <= '0;
            cur_rtt_reg  <= '0;
            cur_ack_reg  <= '0;
            scan_reg     <= '0;
            m_reg        <= '0;
            c_reg        <= '0;
            s_reg        <= '0;
            prod_reg     <= '0;
            p2_reg       <= '0;
            tenss_reg    <= '0;
            den_reg      <= '0;
            ratio_reg    <= '0;
            acc_reg      <= '0;
            sat_reg      <= 1'b0;
            mulsh_reg    <= '0;
            bitcnt_reg   <= '0;
            cwnd_reg     <= '0;
            fallback_reg <= '0;
            limit_reg    <= '0;
            pe_reg       <= '0;
            half_reg     <= '0;
            big_reg      <= 1'b0;
            dec_reg      <= '0;
            o_sub_reg    <= '0;
            o_win_reg    <= '0;
            o_ssth_reg   <= '0;
            o_lim_reg    <= '0;
            o_dec_reg    <= '0;
        end
        else
        begin
            // Configuration transfer
            if (cfg.valid && cfg.ready)
                seg_size_reg <= cfg.segment_size;

            // Table read port
            rd_win_reg  <= win_tab_reg[rd_addr];
            rd_rtt_reg  <= rtt_tab_reg[rd_addr];
            rd_en_reg   <= en_tab_reg[rd_addr];
            rd_ssth_reg <= ssth_tab_reg[rd_addr];
            rd_ack_reg  <= ack_tab_reg[rd_addr];

            case (state_reg)
                S_IDLE:
                begin
                    if (item.valid)
                    begin
                        func_reg   <= item.func;
                        idx_reg    <= item.subflow_index;
                        win_in_reg <= item.window_bytes_in;
                        rtt_in_reg <= item.rtt_micros;
                        state_reg  <= S_RDCUR;
                    end
                end
                S_RDCUR:
                begin
                    state_reg <= S_GOTCUR;
                end
                S_GOTCUR:
                begin
                    cur_win_reg <= rd_win_reg;
                    cur_rtt_reg <= rd_rtt_reg;
                    cur_ack_reg <= rd_ack_reg;
                    o_sub_reg   <= idx_reg;
                    o_win_reg   <= rd_win_reg;
                    o_ssth_reg  <= rd_ssth_reg;
                    o_lim_reg   <= '0;
                    o_dec_reg   <= '0;
                    case (func_reg)
                        bcc_pkg::FUNC_SET:
                        begin
                            win_tab_reg[idx_reg] <= win_in_reg;
                            rtt_tab_reg[idx_reg] <= rtt_in_reg;
                            en_tab_reg[idx_reg]  <= 1'b1;
                            o_win_reg            <= win_in_reg;
                            state_reg            <= S_OUT;
                        end
                        bcc_pkg::FUNC_DISABLE:
                        begin
                            en_tab_reg[idx_reg] <= 1'b0;
                            state_reg           <= S_OUT;
                        end
                        bcc_pkg::FUNC_LOSS:
                        begin
                            state_reg <= (seg_size_reg == 16'd0) ? S_OUT : S_LDIV;
                        end
                        default:
                        begin
                            state_reg <= S_CQDIV;
                        end
                    endcase
                end

                // Window in packets, Q8
                S_CQDIV:
                begin
                    if (div_rsp.done)
                    begin
                        cwnd_reg     <= quot[39:0];
                        fallback_reg <= (quot[39:0] > 40'd256) ? quot[39:0] : 40'd256;
                        scan_reg     <= '0;
                        m_reg        <= '0;
                        c_reg        <= '0;
                        state_reg    <= S_RS_RD;
                    end
                end

                // Rate scan
                S_RS_RD:
                begin
                    state_reg <= S_RS_CHK;
                end
                S_RS_CHK:
                begin
                    if (rd_elig)
                    begin
                        state_reg <= S_RS_DIV;
                    end
                    else
                    begin
                        rate_reg[scan_reg] <= '0;
                        if (scan_reg == LAST_SUB)
                            state_reg <= S_CCHK;
                        else
                        begin
                            scan_reg  <= scan_reg + 1'b1;
                            state_reg <= S_RS_RD;
                        end
                    end
                end
                S_RS_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        rate_reg[scan_reg] <= quot[47:0];
                        if (quot[47:0] > m_reg)
                            m_reg <= quot[47:0];
                        if (scan_reg == idx_reg)
                            c_reg <= quot[47:0];
                        if (scan_reg == LAST_SUB)
                            state_reg <= S_CCHK;
                        else
                        begin
                            scan_reg  <= scan_reg + 1'b1;
                            state_reg <= S_RS_RD;
                        end
                    end
                end

                // Current subflow without a rate takes the fallback
                S_CCHK:
                begin
                    if (c_reg == 48'd0)
                    begin
                        limit_reg <= fallback_reg;
                        state_reg <= S_APPLY;
                    end
                    else
                        state_reg <= S_NORM;
                end

                // Shift all rates until the maximum fits in 18 bits
                S_NORM:
                begin
                    if (m_reg[47:18] != 30'd0)
                    begin
                        for (int i = 0; i < NSUB; i++)
                            rate_reg[i] <= rate_reg[i] >> 1;
                        m_reg <= m_reg >> 1;
                        c_reg <= c_reg >> 1;
                    end
                    else
                    begin
                        s_reg     <= '0;
                        scan_reg  <= '0;
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    s_reg <= s_reg + {3'd0, rate_reg[scan_reg][17:0]};
                    if (scan_reg == LAST_SUB)
                        state_reg <= S_MUL_SS;
                    else
                        scan_reg <= scan_reg + 1'b1;
                end
                S_MUL_SS:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_MUL_DEN;
                end
                S_MUL_DEN:
                begin
                    tenss_reg <= {1'b0, prod_reg[41:0], 3'b000}
                               + {3'b000, prod_reg[41:0], 1'b0};
                    den_reg   <= mul_p[39:0];
                    state_reg <= S_RATIO_ST;
                end
                S_RATIO_ST:
                begin
                    state_reg <= S_RATIO_DIV;
                end
                S_RATIO_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        ratio_reg  <= quot[57:0];
                        acc_reg    <= '0;
                        sat_reg    <= 1'b0;
                        mulsh_reg  <= cwnd_reg;
                        bitcnt_reg <= 6'd40;
                        state_reg  <= S_LIM_MUL;
                    end
                end

                // ratio * cwnd_q8, MSB first, saturating past 2^44
                S_LIM_MUL:
                begin
                    if (!sat_reg)
                    begin
                        if (lim_sum[59:44] != 16'd0)
                            sat_reg <= 1'b1;
                        else
                            acc_reg <= lim_sum[43:0];
                    end
                    mulsh_reg  <= {mulsh_reg[38:0], 1'b0};
                    bitcnt_reg <= bitcnt_reg - 1'b1;
                    if (bitcnt_reg == 6'd1)
                        state_reg <= S_LIM_FIN;
                end
                S_LIM_FIN:
                begin
                    limit_reg <= (lim32 >= 32'd256) ? {8'd0, lim32} : fallback_reg;
                    state_reg <= S_APPLY;
                end

                // Window growth or counter step
                S_APPLY:
                begin
                    o_lim_reg <= limit_reg[31:0];
                    if ({cur_ack_reg, 8'd0} >= limit_reg)
                    begin
                        if (!wsum[32])
                        begin
                            win_tab_reg[idx_reg] <= wsum[31:0];
                            o_win_reg            <= wsum[31:0];
                        end
                        ack_tab_reg[idx_reg] <= '0;
                    end
                    else if (cur_ack_reg != 32'hFFFF_FFFF)
                    begin
                        ack_tab_reg[idx_reg] <= cur_ack_reg + 32'd1;
                    end
                    state_reg <= S_OUT;
                end

                // Loss: packets in window
                S_LDIV:
                begin
                    if (div_rsp.done)
                    begin
                        pe_reg   <= (quot[31:0] == 32'd0) ? 32'd1 : quot[31:0];
                        half_reg <= quot[31:1];
                        big_reg  <= 1'b0;
                        scan_reg <= '0;
                        if (cur_win_reg == 32'd0 || cur_rtt_reg == 24'd0)
                            state_reg <= S_LDEC;
                        else
                            state_reg <= S_LS_RD;
                    end
                end

                // Scan for a subflow at least twice as fast
                S_LS_RD:
                begin
                    state_reg <= S_LS_M1;
                end
                S_LS_M1:
                begin
                    if (rd_elig)
                    begin
                        prod_reg  <= mul_p;
                        state_reg <= S_LS_M2;
                    end
                    else if (scan_reg == LAST_SUB)
                        state_reg <= S_LDEC;
                    else
                    begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= S_LS_RD;
                    end
                end
                S_LS_M2:
                begin
                    p2_reg    <= mul_p;
                    state_reg <= S_LS_CMP;
                end
                S_LS_CMP:
                begin
                    if ({1'b0, prod_reg} >= {p2_reg, 1'b0})
                        big_reg <= 1'b1;
                    if (scan_reg == LAST_SUB)
                        state_reg <= S_LDEC;
                    else
                    begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= S_LS_RD;
                    end
                end
                S_LDEC:
                begin
                    dec_reg   <= (dec_raw > pe_m1) ? pe_m1 : dec_raw;
                    state_reg <= S_LMUL;
                end
                S_LMUL:
                begin
                    ssth_tab_reg[idx_reg] <= mul_p[31:0];
                    ack_tab_reg[idx_reg]  <= '0;
                    o_ssth_reg            <= mul_p[31:0];
                    o_dec_reg             <= (dec_reg[31:24] != 8'd0) ? 24'hFF_FFFF
                                                                      : dec_reg[23:0];
                    state_reg             <= S_OUT;
                end

                // Hold the result until transferred
                S_OUT:
                begin
                    if (result.ready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Channel outputs
    assign cfg.ready                  = 1'b1;
    assign item.ready                 = (state_reg == S_IDLE);
    assign result.valid               = (state_reg == S_OUT);
    assign result.subflow_out         = o_sub_reg;
    assign result.window_bytes_out    = o_win_reg;
    assign result.threshold_bytes_out = o_ssth_reg;
    assign result.increase_limit_q8   = o_lim_reg;
    assign result.decrease_packets    = o_dec_reg;

endmodule

### rtl/bcc_checker.sv
`include "assert_macros.svh"

// Port-level checks of the item/result sequencing
module bcc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      item_valid,
    input logic                      item_ready,
    input logic                      res_valid,
    input logic                      res_ready,
    input logic [bcc_pkg::SUB_W-1:0] res_subflow,
    input logic [31:0]               res_window
);

    // No new item while a result is pending
    `ASSERT_IMPLIES(a_no_accept_with_result, clk, rst_n, res_valid, !item_ready)

    // An accepted item keeps the block busy the following cycle
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, item_valid && item_ready, !item_ready && !res_valid)

    // After a result transfer the block is idle again
    `ASSERT_NEXT(a_idle_after_result, clk, rst_n, res_valid && res_ready, item_ready && !res_valid)

    // A stalled result holds
    `ASSERT_NEXT(a_result_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_subflow) && $stable(res_window))

endmodule

bind multipath_balanced_cwnd_control bcc_checker u_bcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item.valid),
    .item_ready  (item.ready),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_subflow (result.subflow_out),
    .res_window  (result.window_bytes_out)
);

### tb/sv/bcc_tb_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces are provided by the RTL (bcc_ifs.sv); this file holds
// a small helper package with the testbench item and result types.
package bcc_tb_pkg;

    typedef struct {
        logic [1:0]  func;
        logic [2:0]  sub;
        logic [31:0] wnd;
        logic [23:0] rtt;
    } cc_item_t;

    typedef struct {
        logic [2:0]  sub;
        logic [31:0] wnd;
        logic [31:0] ssthresh;
        logic [31:0] limit_q8;
        logic [23:0] dec_pkts;
    } cc_result_t;
endpackage

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 800;
    localparam int NSUB = bcc_pkg::MAX_SUBFLOWS;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   cycle_count;
    bit   quiet_mode;

    bcc_cfg_if    cfg ();
    bcc_item_if   item ();
    bcc_result_if result ();

    multipath_balanced_cwnd_control dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg.sink),
        .item   (item.sink),
        .result (result.source)
    );

    // Clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Shadow copy of the subflow table
    logic [31:0] sh_wnd   [NSUB];
    logic [31:0] sh_ssth  [NSUB];
    logic [31:0] sh_acks  [NSUB];
    logic [23:0] sh_rtt   [NSUB];
    bit          sh_en    [NSUB];
    logic [15:0] sh_mss;

    bcc_tb_pkg::cc_result_t pending_results[$];

    task automatic report(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic bit usable(input int i);
        return sh_en[i] && sh_rtt[i] != 0;
    endfunction

    // Balanced additive-increase threshold, Q24.8 packets
    function automatic logic [63:0] ai_threshold(input int cur);
        logic [63:0] mss, cq8, fb, m, s, c, mr, den, ratio, lim;
        logic [63:0] rt [NSUB];
        int k;
        mss = (sh_mss != 0) ? 64'(sh_mss) : 64'd1;
        cq8 = (64'(sh_wnd[cur]) << 8) / mss;
        fb  = (cq8 > 256) ? cq8 : 64'd256;
        m = 0;
        for (int i = 0; i < NSUB; i++)
        begin
            rt[i] = usable(i) ? (64'(sh_wnd[i]) << 16) / 64'(sh_rtt[i]) : 64'd0;
            if (rt[i] > m) m = rt[i];
        end
        if (!usable(cur) || rt[cur] == 0) return fb;
        k = 0;
        while ((m >> k) >= (64'd1 << 18)) k++;
        s = 0;
        for (int i = 0; i < NSUB; i++) s += rt[i] >> k;
        c  = rt[cur] >> k;
        mr = m >> k;
        den = (c + mr) * (4 * c + mr);
        if (den == 0) return fb;
        ratio = ((10 * s * s) << 12) / den;
        if (cq8 != 0 && ratio > 64'hFFFF_FFFF_FFFF_FFFF / cq8)
            lim = 64'hFFFF_FFFF;
        else
            lim = (ratio * cq8) >> 12;
        if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
        return (lim >= 256) ? lim : fb;
    endfunction

    // Apply one item to the shadow table and produce its result
    function automatic bcc_tb_pkg::cc_result_t cwnd_step(input bcc_tb_pkg::cc_item_t it);
        bcc_tb_pkg::cc_result_t r;
        int x;
        logic [63:0] lim, w, rr, p, half, dec, th;
        bit big;
        x = int'(it.sub);
        lim = 0;
        dec = 0;
        case (it.func)
            bcc_pkg::FUNC_SET:
            begin
                sh_wnd[x] = it.wnd;
                sh_rtt[x] = it.rtt;
                sh_en[x]  = 1'b1;
            end
            bcc_pkg::FUNC_ACK:
            begin
                lim = ai_threshold(x);
                if (64'(sh_acks[x]) * 256 >= lim)
                begin
                    w = 64'(sh_wnd[x]) + 64'(sh_mss);
                    if (w <= 64'hFFFF_FFFF) sh_wnd[x] = w[31:0];
                    sh_acks[x] = 0;
                end
                else if (sh_acks[x] != 32'hFFFF_FFFF)
                    sh_acks[x]++;
            end
            bcc_pkg::FUNC_LOSS:
            begin
                if (sh_mss != 0)
                begin
                    w = 64'(sh_wnd[x]);
                    rr = 64'(sh_rtt[x]);
                    p = w / 64'(sh_mss);
                    half = w / (2 * 64'(sh_mss));
                    dec = half;
                    if (p == 0) p = 1;
                    if (w != 0 && rr != 0)
                    begin
                        big = 0;
                        for (int i = 0; i < NSUB; i++)
                            if (usable(i) && 64'(sh_wnd[i]) * rr >= 2 * w * 64'(sh_rtt[i]))
                                big = 1;
                        if (big) dec = half + (half >> 1);
                    end
                    if (dec > p - 1) dec = p - 1;
                    th = p - dec;
                    if (th == 0) th = 1;
                    sh_ssth[x] = 32'(th * 64'(sh_mss));
                    sh_acks[x] = 0;
                    if (dec > 64'hFF_FFFF) dec = 64'hFF_FFFF;
                end
            end
            default: sh_en[x] = 1'b0;
        endcase
        r.sub = it.sub;
        r.wnd = sh_wnd[x];
        r.ssthresh = sh_ssth[x];
        r.limit_q8 = lim[31:0];
        r.dec_pkts = dec[23:0];
        return r;
    endfunction

    function automatic bit gap_now();
        return !quiet_mode && ($urandom_range(99) < 26);
    endfunction

    // Send one item and queue its expected result; valid stays high after
    // the transfer so that items can follow without a gap
    task automatic send_item(input bcc_tb_pkg::cc_item_t it);
        while (gap_now())
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid <= 1'b1;
        item.func <= it.func;
        item.subflow_index <= it.sub;
        item.window_bytes_in <= it.wnd;
        item.rtt_micros <= it.rtt;
        @(posedge clk);
        while (!item.ready) @(posedge clk);
        pending_results.push_back(cwnd_step(it));
    endtask

    // Write the segment size once all results are back
    task automatic write_mss(input logic [15:0] v);
        item.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.segment_size <= v;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        sh_mss = v;
    endtask

    // Result sink with random backpressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                bcc_tb_pkg::cc_result_t e;
                if (pending_results.size() == 0)
                    report("result transfer with nothing expected");
                else
                begin
                    e = pending_results.pop_front();
                    if (result.subflow_out !== e.sub)
                        report($sformatf("subflow got %0d exp %0d", result.subflow_out, e.sub));
                    if (result.window_bytes_out !== e.wnd)
                        report($sformatf("sub %0d window got %0h exp %0h", e.sub,
                            result.window_bytes_out, e.wnd));
                    if (result.threshold_bytes_out !== e.ssthresh)
                        report($sformatf("sub %0d ssthresh got %0h exp %0h", e.sub,
                            result.threshold_bytes_out, e.ssthresh));
                    if (result.increase_limit_q8 !== e.limit_q8)
                        report($sformatf("sub %0d limit got %0h exp %0h", e.sub,
                            result.increase_limit_q8, e.limit_q8));
                    if (result.decrease_packets !== e.dec_pkts)
                        report($sformatf("sub %0d decrease got %0h exp %0h", e.sub,
                            result.decrease_packets, e.dec_pkts));
                end
            end
            result.ready <= !gap_now();
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Directed rows: func, index, window, rtt, expected result checks via predictor
    typedef struct {
        logic [1:0]  func;
        logic [2:0]  sub;
        logic [31:0] wnd;
        logic [23:0] rtt;
        bit          has_exp;
        logic [31:0] exp_wnd;
        logic [31:0] exp_ssth;
    } dir_row_t;

    dir_row_t dir_rows[] = '{
        '{bcc_pkg::FUNC_ACK,     3'd0, 32'd0,         24'd0,       1, 32'd0, 32'hFFFF_FFFF},
        '{bcc_pkg::FUNC_LOSS,    3'd1, 32'd0,         24'd0,       1, 32'd0, 32'd1460},
        '{bcc_pkg::FUNC_DISABLE, 3'd7, 32'd0,         24'd0,       1, 32'd0, 32'hFFFF_FFFF},
        '{bcc_pkg::FUNC_SET,     3'd0, 32'd14600,     24'd1000,    1, 32'd14600, 32'hFFFF_FFFF},
        '{bcc_pkg::FUNC_SET,     3'd1, 32'd29200,     24'd1000,    0, 0, 0},
        '{bcc_pkg::FUNC_SET,     3'd2, 32'hFFFF_FFFF, 24'hFF_FFFF, 0, 0, 0},
        '{bcc_pkg::FUNC_SET,     3'd7, 32'hFFFF_FFFF, 24'd1,       0, 0, 0},
        '{bcc_pkg::FUNC_ACK,     3'd0, 32'd0,         24'd0,       0, 0, 0},
        '{bcc_pkg::FUNC_ACK,     3'd0, 32'd0,         24'd0,       0, 0, 0},
        '{bcc_pkg::FUNC_ACK,     3'd7, 32'd0,         24'd0,       0, 0, 0},
        '{bcc_pkg::FUNC_ACK,     3'd7, 32'd0,         24'd0,       0, 0, 0},
        '{bcc_pkg::FUNC_LOSS,    3'd0, 32'd0,         24'd0,       0, 0, 0},
        '{bcc_pkg::FUNC_LOSS,    3'd7, 32'd0,         24'd0,       0, 0, 0},
        '{bcc_pkg::FUNC_LOSS,    3'd2, 32'd0,         24'd0,       0, 0, 0},
        '{bcc_pkg::FUNC_SET,     3'd3, 32'd100,       24'd0,       0, 0, 0},
        '{bcc_pkg::FUNC_ACK,     3'd3, 32'd0,         24'd0,       0, 0, 0},
        '{bcc_pkg::FUNC_LOSS,    3'd3, 32'd0,         24'd0,       0, 0, 0},
        '{bcc_pkg::FUNC_DISABLE, 3'd1, 32'd0,         24'd0,       0, 0, 0},
        '{bcc_pkg::FUNC_ACK,     3'd1, 32'd0,         24'd0,       0, 0, 0},
        '{bcc_pkg::FUNC_ACK,     3'd0, 32'd0,         24'd0,       0, 0, 0}
    };

    function automatic bcc_tb_pkg::cc_item_t rand_item(input bit tiny);
        bcc_tb_pkg::cc_item_t it;
        it.func = $urandom_range(9) < 2 ? bcc_pkg::FUNC_SET :
                  ($urandom_range(9) < 7 ? bcc_pkg::FUNC_ACK :
                  ($urandom_range(3) < 3 ? bcc_pkg::FUNC_LOSS : bcc_pkg::FUNC_DISABLE));
        it.sub = 3'($urandom_range(7));
        case ($urandom_range(3))
            0: it.wnd = $urandom();
            1: it.wnd = $urandom_range(200000);
            2: it.wnd = tiny ? $urandom_range(20) : $urandom_range(5000);
            default: it.wnd = 32'hFFFF_FFFF - $urandom_range(3000);
        endcase
        case ($urandom_range(3))
            0: it.rtt = 24'($urandom());
            1: it.rtt = 24'($urandom_range(100000));
            2: it.rtt = 24'($urandom_range(3));
            default: it.rtt = 24'hFF_FFFF;
        endcase
        return it;
    endfunction

    initial
    begin
        bcc_tb_pkg::cc_item_t it;
        logic [15:0] mss_list[];
        mss_list = '{16'd1460, 16'd1, 16'hFFFF, 16'd0, 16'd536, 16'd9000};
        fail_count = 0;
        cycle_count = 0;
        quiet_mode = 0;
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.segment_size = '0;
        item.valid = 1'b0;
        item.func = bcc_pkg::FUNC_SET;
        item.subflow_index = '0;
        item.window_bytes_in = '0;
        item.rtt_micros = '0;
        result.ready = 1'b0;
        for (int i = 0; i < NSUB; i++)
        begin
            sh_wnd[i] = 0;
            sh_ssth[i] = 32'hFFFF_FFFF;
            sh_acks[i] = 0;
            sh_rtt[i] = 0;
            sh_en[i] = 0;
        end
        sh_mss = bcc_pkg::SEG_SIZE_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (dir_rows[n])
        begin
            it.func = dir_rows[n].func;
            it.sub = dir_rows[n].sub;
            it.wnd = dir_rows[n].wnd;
            it.rtt = dir_rows[n].rtt;
            send_item(it);
            if (dir_rows[n].has_exp &&
                (pending_results[$].wnd !== dir_rows[n].exp_wnd ||
                 pending_results[$].ssthresh !== dir_rows[n].exp_ssth))
                report($sformatf("directed row %0d predictor disagrees with table", n));
        end

        // Random phases across segment sizes
        foreach (mss_list[p])
        begin
            write_mss(mss_list[p]);
            quiet_mode = (p == 2);
            for (int n = 0; n < 85; n++)
                send_item(rand_item(mss_list[p] < 2));
        end
        quiet_mode = 0;
        item.valid <= 1'b0;

        // Drain
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
